### src/fapcc_pkg.sv
// fapcc_pkg: shared types and constants of the force/angle PI current controller.
// No dependencies; imported by force_angle_pi_current_control.
package fapcc_pkg;

    localparam int FRAC_BITS_DEF      = 8;
    localparam int INTEGRAL_WIDTH_DEF = 48;
    localparam int LOAD_AVG_WIDTH     = 40;
    localparam int LOAD_RESET         = -391500;

    localparam int IN_WIDTH  = 56;
    localparam int OUT_WIDTH = 96;
    localparam int CFG_WIDTH = 24;

    localparam logic [15:0] PROP_GAIN_RST  = 16'd1024;
    localparam logic [15:0] INT_GAIN_RST   = 16'd128;
    localparam logic [15:0] ALPHA_RST      = 16'd6554;
    localparam logic [15:0] PWM_TOP_RST    = 16'd6250;
    localparam logic [15:0] DEAD_BAND_RST  = 16'd30;

    localparam logic [5:0] FORCE_DIV = 6'd25;
    localparam logic [5:0] CUR_DIV   = 6'd3;

    localparam logic signed [15:0] ANGLE_FAR  = 16'sd1440;
    localparam logic signed [15:0] ANGLE_NEAR = 16'sd320;
    localparam logic [24:0] FORCE_LO = 25'd1500;
    localparam logic [24:0] FORCE_HI = 25'd5500;
    localparam int          FAR_CURRENT = 1000;

    typedef enum logic [2:0] {
        REG_PROP_GAIN = 3'd0,
        REG_INT_GAIN  = 3'd1,
        REG_OFFSET    = 3'd2,
        REG_ALPHA     = 3'd3,
        REG_PWM_TOP   = 3'd4,
        REG_DEAD_BAND = 3'd5
    } fapcc_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_MULA,
        ST_AVG,
        ST_NET,
        ST_TGT,
        ST_DIV,
        ST_ERR,
        ST_INT,
        ST_MULC,
        ST_DONE
    } fapcc_state_t;

endpackage

### src/force_angle_pi_current_control.sv
// force_angle_pi_current_control: load smoothing, current target selection, PI loop, H-bridge.
// Depends on fapcc_pkg.
//
// Usage:
//   Input stream s_axis_*: one request per control tick carrying load_sample, shaft_angle
//   and current_raw. Output stream m_axis_*: one request per input with both bridge
//   levels, the current target, the net force and the drive value.
//   cfg_we/cfg_index/cfg_wdata write the gain, offset, smoothing, PWM and dead band
//   registers; write only while no request is in flight.
//   The engine steps through a bit-serial shift-add multiply by the average weight,
//   then two restoring dividers by 25 and by 3 that run side by side, then one
//   bit-serial shift-add multiply that applies both PI gains together. One request
//   is worked at a time, so no new request is taken before the last one is done.
//   s_axis_tready is high only when the engine is idle.
//   A finished result waits in the output register while m_axis_tready is low; the
//   engine holds in its last step until the register frees, so nothing is lost.
//   Reset restores default registers, the load average and a cleared integrator.
module force_angle_pi_current_control #(
    parameter int FRAC_BITS      = fapcc_pkg::FRAC_BITS_DEF,
    parameter int INTEGRAL_WIDTH = fapcc_pkg::INTEGRAL_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // load_sample[23:0], shaft_angle[39:24], current_raw[55:40]
    input  logic [fapcc_pkg::IN_WIDTH-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // level_a[15:0], level_b[31:16], target_current[47:32], net_force[72:48],
    // drive_value[89:73], zero[95:90]
    output logic [fapcc_pkg::OUT_WIDTH-1:0]  m_axis_tdata,
    input  logic                             cfg_we,
    input  logic [2:0]                       cfg_index,
    input  logic [fapcc_pkg::CFG_WIDTH-1:0]  cfg_wdata
);
    import fapcc_pkg::*;

    localparam int AW  = LOAD_AVG_WIDTH;
    localparam int DFW = AW + 1;
    localparam int NTW = AW + 2;
    localparam int TW  = FRAC_BITS + 14;
    localparam int EW  = FRAC_BITS + 17;
    localparam int DW  = FRAC_BITS + 16;
    localparam int IW  = INTEGRAL_WIDTH;
    localparam int CW  = (IW + 18 > DFW + 17) ? IW + 18 : DFW + 17;
    localparam int DCW = $clog2(DW + 1);
    localparam int SH  = FRAC_BITS + 8;

    fapcc_state_t state_reg, state_next;

    logic [15:0]             prop_gain_reg, int_gain_reg, alpha_reg, pwm_top_reg, dead_band_reg;
    logic signed [23:0]      offset_reg;
    logic signed [AW-1:0]    load_avg_reg;
    logic signed [IW-1:0]    integ_reg;

    logic signed [23:0]      sample_reg;
    logic signed [15:0]      angle_reg, raw_reg;
    logic signed [24:0]      net_reg;
    logic                    win_reg;
    logic signed [CW-1:0]    acc_reg, mca_reg, mcb_reg;
    logic [15:0]             gx_reg, gy_reg;
    logic [3:0]              cnt_reg;
    logic [DCW-1:0]          dcnt_reg;
    logic [DW-1:0]           fn_reg, cn_reg;
    logic [5:0]              frem_reg, crem_reg;
    logic signed [TW-1:0]    target_reg;
    logic signed [EW-1:0]    err_reg;
    logic                    out_valid_reg;
    logic [OUT_WIDTH-1:0]    out_data_reg;

    logic signed [DFW-1:0]   diff_c;
    logic signed [CW-1:0]    addend_c;
    logic signed [NTW-1:0]   nt_c, nq_c;
    logic [24:0]             net_mag_c;
    logic [15:0]             raw_mag_c;
    logic [5:0]              fr2_c, cr2_c;
    logic                    fbit_c, cbit_c;
    logic signed [TW-1:0]    force_t_c, angle_t_c, target_c;
    logic signed [EW-1:0]    cur_c;
    logic signed [IW:0]      isum_c;
    logic signed [IW-1:0]    integ_new_c;
    logic signed [CW-1:0]    dq_c, top_c;
    logic signed [16:0]      drive_c, clamp_c, db_c;
    logic [15:0]             la_c, lb_c;
    logic signed [TW-1:0]    tq_c;
    logic                    out_free_c;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_free_c    = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        diff_c   = (DFW'(sample_reg) <<< FRAC_BITS) - DFW'(load_avg_reg);
        addend_c = (gx_reg[0] ? mca_reg : '0) + (gy_reg[0] ? mcb_reg : '0);

        nt_c = NTW'(load_avg_reg) - (NTW'(offset_reg) <<< FRAC_BITS);
        nq_c = nt_c >>> FRAC_BITS;
        if (nt_c[NTW-1] && (nt_c[FRAC_BITS-1:0] != '0))
        begin
            nq_c = nq_c + NTW'(1);
        end

        net_mag_c = net_reg[24] ? 25'(-net_reg) : 25'(net_reg);
        raw_mag_c = raw_reg[15] ? 16'(-raw_reg) : 16'(raw_reg);

        fr2_c  = {frem_reg[4:0], fn_reg[DW-1]};
        fbit_c = (fr2_c >= FORCE_DIV);
        cr2_c  = {crem_reg[4:0], cn_reg[DW-1]};
        cbit_c = (cr2_c >= CUR_DIV);

        force_t_c = net_reg[24] ? TW'(fn_reg) : -TW'(fn_reg);
        cur_c     = raw_reg[15] ? -EW'(cn_reg) : EW'(cn_reg);
        angle_t_c = -(TW'(angle_reg) <<< (FRAC_BITS - 3));
        if (angle_reg > ANGLE_FAR)
        begin
            target_c = -(TW'(FAR_CURRENT) <<< FRAC_BITS);
        end
        else if (angle_reg < -ANGLE_FAR)
        begin
            target_c = TW'(FAR_CURRENT) <<< FRAC_BITS;
        end
        else if (angle_reg > -ANGLE_NEAR && angle_reg < ANGLE_NEAR)
        begin
            target_c = win_reg ? force_t_c : '0;
        end
        else
        begin
            target_c = angle_t_c;
        end

        isum_c = (IW + 1)'(integ_reg) + (IW + 1)'(err_reg);
        if (isum_c[IW] != isum_c[IW-1])
        begin
            integ_new_c = isum_c[IW] ? {1'b1, {(IW - 1){1'b0}}} : {1'b0, {(IW - 1){1'b1}}};
        end
        else
        begin
            integ_new_c = isum_c[IW-1:0];
        end

        dq_c = acc_reg >>> SH;
        if (acc_reg[CW-1] && (acc_reg[SH-1:0] != '0))
        begin
            dq_c = dq_c + CW'(1);
        end
        top_c = CW'({1'b0, pwm_top_reg});
        if (dq_c > top_c)
        begin
            clamp_c = 17'({1'b0, pwm_top_reg});
        end
        else if (dq_c < -top_c)
        begin
            clamp_c = -17'({1'b0, pwm_top_reg});
        end
        else
        begin
            clamp_c = 17'(dq_c);
        end
        db_c = 17'({1'b0, dead_band_reg});
        drive_c = (clamp_c > -db_c && clamp_c < db_c) ? '0 : clamp_c;
        if (drive_c[16])
        begin
            la_c = pwm_top_reg + drive_c[15:0];
            lb_c = pwm_top_reg;
        end
        else
        begin
            la_c = pwm_top_reg;
            lb_c = pwm_top_reg - drive_c[15:0];
        end

        tq_c = target_reg >>> FRAC_BITS;
        if (target_reg[TW-1] && (target_reg[FRAC_BITS-1:0] != '0))
        begin
            tq_c = tq_c + TW'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_axis_tvalid) state_next = ST_DIFF;
            ST_DIFF: state_next = ST_MULA;
            ST_MULA: if (cnt_reg == 4'hF) state_next = ST_AVG;
            ST_AVG:  state_next = ST_NET;
            ST_NET:  state_next = ST_TGT;
            ST_TGT:  state_next = ST_DIV;
            ST_DIV:  if (dcnt_reg == DCW'(DW - 1)) state_next = ST_ERR;
            ST_ERR:  state_next = ST_INT;
            ST_INT:  state_next = ST_MULC;
            ST_MULC: if (cnt_reg == 4'hF) state_next = ST_DONE;
            ST_DONE: if (out_free_c) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            prop_gain_reg <= PROP_GAIN_RST;
            int_gain_reg  <= INT_GAIN_RST;
            offset_reg    <= '0;
            alpha_reg     <= ALPHA_RST;
            pwm_top_reg   <= PWM_TOP_RST;
            dead_band_reg <= DEAD_BAND_RST;
            load_avg_reg  <= AW'(LOAD_RESET) <<< FRAC_BITS;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_PROP_GAIN: prop_gain_reg <= cfg_wdata[15:0];
                    REG_INT_GAIN:  int_gain_reg  <= cfg_wdata[15:0];
                    REG_OFFSET:    offset_reg    <= cfg_wdata;
                    REG_ALPHA:     alpha_reg     <= cfg_wdata[15:0];
                    REG_PWM_TOP:   pwm_top_reg   <= cfg_wdata[15:0];
                    REG_DEAD_BAND: dead_band_reg <= cfg_wdata[15:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_AVG)
            begin
                load_avg_reg <= load_avg_reg + AW'(acc_reg >>> 16);
            end
            if (state_reg == ST_INT)
            begin
                integ_reg <= integ_new_c;
            end
            if (state_reg == ST_DONE && out_free_c)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                sample_reg <= s_axis_tdata[23:0];
                angle_reg  <= s_axis_tdata[39:24];
                raw_reg    <= s_axis_tdata[55:40];
            end
            ST_DIFF:
            begin
                mca_reg <= CW'(diff_c);
                mcb_reg <= '0;
                gx_reg  <= alpha_reg;
                gy_reg  <= '0;
                acc_reg <= '0;
                cnt_reg <= '0;
            end
            ST_MULA, ST_MULC:
            begin
                acc_reg <= acc_reg + addend_c;
                mca_reg <= mca_reg <<< 1;
                mcb_reg <= mcb_reg <<< 1;
                gx_reg  <= gx_reg >> 1;
                gy_reg  <= gy_reg >> 1;
                cnt_reg <= cnt_reg + 4'd1;
            end
            ST_NET:
            begin
                net_reg <= 25'(nq_c);
            end
            ST_TGT:
            begin
                win_reg  <= (net_mag_c > FORCE_LO) && (net_mag_c < FORCE_HI);
                fn_reg   <= DW'(net_mag_c[12:0]) << (FRAC_BITS + 1);
                cn_reg   <= DW'(raw_mag_c) << FRAC_BITS;
                frem_reg <= '0;
                crem_reg <= '0;
                dcnt_reg <= '0;
            end
            ST_DIV:
            begin
                frem_reg <= fbit_c ? fr2_c - FORCE_DIV : fr2_c;
                crem_reg <= cbit_c ? cr2_c - CUR_DIV : cr2_c;
                fn_reg   <= {fn_reg[DW-2:0], fbit_c};
                cn_reg   <= {cn_reg[DW-2:0], cbit_c};
                dcnt_reg <= dcnt_reg + DCW'(1);
            end
            ST_ERR:
            begin
                target_reg <= target_c;
                err_reg    <= EW'(target_c) - cur_c;
            end
            ST_INT:
            begin
                mca_reg <= CW'(err_reg);
                mcb_reg <= CW'(integ_new_c);
                gx_reg  <= prop_gain_reg;
                gy_reg  <= int_gain_reg;
                acc_reg <= '0;
                cnt_reg <= '0;
            end
            ST_DONE:
            begin
                if (out_free_c)
                begin
                    out_data_reg <= {6'd0, drive_c, net_reg, 16'(tq_c), lb_c, la_c};
                end
            end
            default: ;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_DIFF && !s_axis_tready))
        else $error("accepted request did not start the engine");

    a_done_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free_c) |=> (m_axis_tvalid && state_reg == ST_IDLE))
        else $error("finished request not presented");

    a_level_top: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[15:0] == pwm_top_reg || m_axis_tdata[31:16] == pwm_top_reg))
        else $error("neither bridge level at full scale");
`endif

endmodule

### test/force_angle_pi_current_control_test.sv
// Self-checking testbench for force_angle_pi_current_control: a directed table, then random
// load/angle/current streams under several register settings, with a built-in predictor.
// Depends on fapcc_pkg and the force_angle_pi_current_control RTL.
module force_angle_pi_current_control_test;
    timeunit 1ns;
    timeprecision 1ps;

    import fapcc_pkg::*;

    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          ITEMS_PHASE  = 175;
    localparam int          NUM_PHASES   = 8;
    localparam int          DRAIN_CYCLES = 80;
    localparam logic [2:0]  IDX_SPARE_LO = 3'd6;
    localparam logic [2:0]  IDX_SPARE_HI = 3'd7;

    typedef struct {
        logic [15:0] lvl_a;
        logic [15:0] lvl_b;
        logic [15:0] tgt;
        logic [24:0] net;
        logic [16:0] drv;
    } bridge_out_t;

    typedef struct {
        logic [23:0] ld;
        logic [15:0] ang;
        logic [15:0] cur;
        bit          typed;
        bridge_out_t res;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_WIDTH-1:0]  s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_WIDTH-1:0] m_axis_tdata;
    logic                 cfg_we = 1'b0;
    logic [2:0]           cfg_index = REG_PROP_GAIN;
    logic [CFG_WIDTH-1:0] cfg_wdata = '0;

    force_angle_pi_current_control u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // predictor state and register copy
    longint kp, ki, offset, alpha, top, dband;
    longint load_avg, err_integ;

    bridge_out_t expected_bridge[$];
    int          error_count = 0;
    int          sent_count = 0;
    int          idle_mode = 0;
    longint      cycle_count = 0;
    bit          hold_off = 1'b0;

    int cfg_set [NUM_PHASES][6] = '{
        '{1024, 128, 0, 6554, 6250, 30},
        '{0, 0, 100000, 65535, 65535, 0},
        '{65535, 65535, -8388608, 0, 1, 0},
        '{2048, 256, 8388607, 32768, 0, 30},
        '{512, 64, -50000, 6554, 100, 200},
        '{1024, 0, 0, 1, 6250, 65535},
        '{300, 900, 12345, 20000, 3000, 10},
        '{1024, 128, 0, 6554, 6250, 30}
    };

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("force_angle_pi_current_control_test: done, errors");
            $finish;
        end
    end

    function automatic longint floor_div(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic bridge_out_t predict_bridge(logic [23:0] ld, logic [15:0] ang,
                                                   logic [15:0] cr);
        longint      sample, angle, raw, net, target, current, err;
        longint      iterm, lim, drive, tgt_mA;
        longint      integ_hi;
        bridge_out_t r;
        sample   = longint'($signed(ld));
        angle    = longint'($signed(ang));
        raw      = longint'($signed(cr));
        integ_hi = (longint'(1) <<< 47) - 1;

        load_avg = load_avg + floor_div((sample * 256 - load_avg) * alpha, 65536);
        net = (load_avg - offset * 256) / 256;

        if (angle > 1440)
            target = -1000 * 256;
        else if (angle < -1440)
            target = 1000 * 256;
        else if (angle > -320 && angle < 320)
        begin
            if ((net > 1500 && net < 5500) || (net < -1500 && net > -5500))
                target = (-2 * net * 256) / 25;
            else
                target = 0;
        end
        else
            target = (-angle * 256) / 8;

        current = (raw * 256) / 3;
        err = target - current;
        err_integ = err_integ + err;
        if (err_integ > integ_hi)
            err_integ = integ_hi;
        if (err_integ < -integ_hi - 1)
            err_integ = -integ_hi - 1;

        if (ki == 0)
            iterm = 0;
        else
        begin
            lim = (longint'(1) <<< 60) / ki;
            if (err_integ > lim)
                iterm = longint'(1) <<< 60;
            else if (err_integ < -lim)
                iterm = -(longint'(1) <<< 60);
            else
                iterm = ki * err_integ;
        end
        drive = (kp * err + iterm) / 65536;
        if (drive > top)
            drive = top;
        if (drive < -top)
            drive = -top;
        if (drive > -dband && drive < dband)
            drive = 0;

        if (drive >= 0)
        begin
            r.lvl_a = top[15:0];
            r.lvl_b = 16'(top - drive);
        end
        else
        begin
            r.lvl_a = 16'(top + drive);
            r.lvl_b = top[15:0];
        end
        tgt_mA = target / 256;
        if (tgt_mA > 32767)
            tgt_mA = 32767;
        if (tgt_mA < -32768)
            tgt_mA = -32768;
        r.tgt = 16'(tgt_mA);
        r.net = 25'(net);
        r.drv = 17'(drive);
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0d (0x%0h) expected %0d (0x%0h) at cycle %0d",
                 field, got, got, want, want, cycle_count);
        error_count++;
    endtask

    // output side: check every accepted result, stall at random except in idle mode 2
    always @(posedge clk)
    begin
        bridge_out_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_bridge.size() == 0)
                    report_mismatch("unexpected result", 32'(m_axis_tdata[31:0]), 32'd0);
                else
                begin
                    want = expected_bridge.pop_front();
                    if (m_axis_tdata[15:0] !== want.lvl_a)
                        report_mismatch("level_a", 32'(m_axis_tdata[15:0]), 32'(want.lvl_a));
                    if (m_axis_tdata[31:16] !== want.lvl_b)
                        report_mismatch("level_b", 32'(m_axis_tdata[31:16]), 32'(want.lvl_b));
                    if (m_axis_tdata[47:32] !== want.tgt)
                        report_mismatch("target_current", 32'(m_axis_tdata[47:32]),
                                        32'(want.tgt));
                    if (m_axis_tdata[72:48] !== want.net)
                        report_mismatch("net_force", 32'(m_axis_tdata[72:48]), 32'(want.net));
                    if (m_axis_tdata[89:73] !== want.drv)
                        report_mismatch("drive_value", 32'(m_axis_tdata[89:73]),
                                        32'(want.drv));
                    if (m_axis_tdata[95:90] !== 6'd0)
                        report_mismatch("pad bits", 32'(m_axis_tdata[95:90]), 32'd0);
                end
            end
            if (hold_off)
                m_axis_tready <= 1'b0;
            else if (idle_mode == 2)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= ((idle_mode == 0) ? 72 : 28));
        end
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (sent_count >= 30);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic write_reg(logic [2:0] idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[CFG_WIDTH-1:0];
        @(posedge clk);
        case (idx)
            REG_PROP_GAIN: kp     = longint'(value[15:0]);
            REG_INT_GAIN:  ki     = longint'(value[15:0]);
            REG_OFFSET:    offset = longint'($signed(value[23:0]));
            REG_ALPHA:     alpha  = longint'(value[15:0]);
            REG_PWM_TOP:   top    = longint'(value[15:0]);
            REG_DEAD_BAND: dband  = longint'(value[15:0]);
            default: ;
        endcase
    endtask

    task automatic load_settings(int p);
        while (expected_bridge.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_PROP_GAIN, cfg_set[p][0]);
        write_reg(IDX_SPARE_LO, int'($urandom));
        write_reg(REG_INT_GAIN, cfg_set[p][1]);
        write_reg(REG_OFFSET, cfg_set[p][2]);
        write_reg(REG_ALPHA, cfg_set[p][3]);
        write_reg(IDX_SPARE_HI, int'($urandom));
        write_reg(REG_PWM_TOP, cfg_set[p][4]);
        write_reg(REG_DEAD_BAND, cfg_set[p][5]);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_request(logic [23:0] ld, logic [15:0] ang, logic [15:0] cr,
                                bit typed, bridge_out_t typed_res);
        int          gap_pct;
        bridge_out_t r;
        gap_pct = (idle_mode == 0) ? 28 : ((idle_mode == 1) ? 72 : 0);
        while ($urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cr, ang, ld};
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        r = predict_bridge(ld, ang, cr);
        if (typed)
        begin
            r.lvl_a = typed_res.lvl_a;
            r.lvl_b = typed_res.lvl_b;
            r.tgt   = typed_res.tgt;
            r.drv   = typed_res.drv;
        end
        expected_bridge.push_back(r);
        sent_count++;
    endtask

    function automatic logic [23:0] clamp_load(int v);
        if (v > 8388607)
            v = 8388607;
        if (v < -8388608)
            v = -8388608;
        return v[23:0];
    endfunction

    function automatic logic [15:0] pick_angle();
        int k;
        int edges [10] = '{1440, 1441, -1440, -1441, 319, 320, -319, -320, 32767, -32768};
        k = $urandom_range(3);
        case (k)
            0: return 16'($urandom_range(638) - 319);
            1: return 16'($urandom_range(2880) - 1440);
            2: return 16'($urandom);
            default: return 16'(edges[$urandom_range(9)]);
        endcase
    endfunction

    stim_row_t directed [] = '{
        '{24'd0, 16'sd2000, 16'sd32767, 1'b1,
          '{16'd0, 16'd6250, -16'sd1000, 25'd0, -17'sd6250}},
        '{24'd0, -16'sd32768, -16'sd32768, 1'b1,
          '{16'd6250, 16'd0, 16'sd1000, 25'd0, 17'sd6250}},
        '{24'h7FFFFF, 16'sd0, 16'sd0, 1'b0, '{default: '0}},
        '{24'h800000, 16'sd0, 16'sd0, 1'b0, '{default: '0}},
        '{24'h7FFFFF, 16'sd1440, 16'sd1, 1'b0, '{default: '0}},
        '{24'h000000, 16'sd1441, -16'sd1, 1'b0, '{default: '0}},
        '{24'h000000, -16'sd1440, 16'sd3, 1'b0, '{default: '0}},
        '{24'h000000, -16'sd1441, -16'sd3, 1'b0, '{default: '0}},
        '{24'h001000, 16'sd319, 16'sd0, 1'b0, '{default: '0}},
        '{24'h001000, 16'sd320, 16'sd0, 1'b0, '{default: '0}},
        '{24'hFFF000, -16'sd319, 16'sd100, 1'b0, '{default: '0}},
        '{24'hFFF000, -16'sd320, -16'sd100, 1'b0, '{default: '0}},
        '{24'h000000, -16'sd321, 16'sd0, 1'b0, '{default: '0}},
        '{24'h000000, 16'sd321, 16'sd0, 1'b0, '{default: '0}},
        '{24'h000000, 16'sd32767, 16'sd32767, 1'b0, '{default: '0}},
        '{24'h000000, -16'sd32768, 16'sd32767, 1'b0, '{default: '0}},
        '{24'h555555, 16'h5555, 16'h5555, 1'b0, '{default: '0}},
        '{24'hAAAAAA, 16'hAAAA, 16'hAAAA, 1'b0, '{default: '0}}
    };

    initial
    begin
        int          cnt, seglen, f, noise;
        logic [23:0] ld;
        logic [15:0] ang, cr;
        bridge_out_t none;
        none = '{default: '0};
        kp = 1024; ki = 128; offset = 0; alpha = 6554; top = 6250; dband = 30;
        load_avg  = longint'(LOAD_RESET) * 256;
        err_integ = 0;
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_request(directed[i].ld, directed[i].ang, directed[i].cur,
                         directed[i].typed, directed[i].res);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            s_axis_tvalid <= 1'b0;
            load_settings(p);
            idle_mode = (p * 3) / NUM_PHASES;
            cnt = 0;
            while (cnt < ITEMS_PHASE)
            begin
                seglen = $urandom_range(40, 10);
                f = ($urandom_range(9) == 0) ? int'($urandom) : int'($urandom_range(14000)) - 7000;
                for (int k = 0; k < seglen && cnt < ITEMS_PHASE; k++)
                begin
                    noise = int'($urandom_range(100)) - 50;
                    if ($urandom_range(99) < 15)
                        ld = 24'($urandom);
                    else
                        ld = clamp_load(int'(offset) + f + noise);
                    ang = pick_angle();
                    if ($urandom_range(1) == 0)
                        cr = 16'($urandom_range(12000) - 6000);
                    else
                        cr = 16'($urandom);
                    send_request(ld, ang, cr, 1'b0, none);
                    cnt++;
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        while (expected_bridge.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("force_angle_pi_current_control_test: done, clean");
        else
            $display("force_angle_pi_current_control_test: done, errors");
        $finish;
    end

endmodule
